// ===== hw/rtl/plb_pkg.sv =====
// Shared types and constants for the line printer buffer.
`default_nettype none
package plb_pkg;

  localparam int LINE_CAPACITY_DEF = 40;

  localparam int CHAR_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int TICK_W  = 16;
  localparam int BUSY_W  = 24;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PRINTER_OFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TICKS  = 1'b1;

  localparam logic [BUSY_W-1:0] BUSY_TICKS_RST = 24'd800000;

  localparam logic [CHAR_W-1:0] CHAR_CR     = 7'h0D;
  localparam logic [CHAR_W-1:0] PRINT_LO    = 7'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI    = 7'h5F;
  localparam logic [CHAR_W-1:0] LOWER_A     = 7'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z     = 7'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'h20;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_STATUS = 5'b00100,
    ST_READ   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/plb_in_if.sv =====
// Input item channel.
`default_nettype none
interface plb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [plb_pkg::BYTE_W-1:0] char_byte;
  logic [plb_pkg::TICK_W-1:0] tick_count;

  modport source (output valid, operation, char_byte, tick_count, input ready);
  modport sink   (input valid, operation, char_byte, tick_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/plb_out_if.sv =====
// Result item channel.
`default_nettype none
interface plb_out_if #(
  parameter int LVL_W = 6
);
  logic                       valid;
  logic                       ready;
  logic                       line_valid;
  logic [plb_pkg::CHAR_W-1:0] line_char;
  logic                       empty_line;
  logic                       last;
  logic                       mech_busy;
  logic [LVL_W-1:0]           buffer_level;
  logic [plb_pkg::CNT_W-1:0]  chars_accepted;
  logic [plb_pkg::CNT_W-1:0]  lines_printed;

  modport source (output valid, line_valid, line_char, empty_line, last, mech_busy,
                  buffer_level, chars_accepted, lines_printed, input ready);
  modport sink   (input valid, line_valid, line_char, empty_line, last, mech_busy,
                  buffer_level, chars_accepted, lines_printed, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/plb_cfg_if.sv =====
// Configuration write channel.
`default_nettype none
interface plb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [plb_pkg::CFG_IDX_W-1:0]  index;
  logic [plb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/printer_line_buffer.sv =====
// Line printer buffer: top level with sequencer, counters and output register.
//
// Channels: in_ch takes items (a character write or a tick item), out_ch returns
// results, cfg_ch writes printer_off (index 0) and mech_busy_ticks (index 1);
// cfg_ch is always ready; it must be written only while the block is idle, but
// the block itself does not enforce this. One item is handled at a time; in_ch
// is ready only while the sequencer idles. An item that gives one status result
// passes the execute and status states before its result is loaded into the
// output register. A printed line reads each character from the memory and
// then loads it into the output register; an empty line gives one status result.
// Results stand in an output register; the next item may be accepted while
// the last result of the previous one still waits there.
// When the receiver stalls, the sequencer holds on the pending result.
// Reset clears the buffer level, busy counter, both running counts and the
// configuration to its defaults (printer on, 800000 busy ticks). The line
// memory needs no clearing since only entries below the level are read.
`default_nettype none
module printer_line_buffer #(
  parameter int LINE_CAPACITY = plb_pkg::LINE_CAPACITY_DEF,
  parameter int LVL_W  = $clog2(LINE_CAPACITY + 1),
  parameter int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
  input  wire         clk,
  input  wire         rst_n,
  plb_in_if.sink      in_ch,
  plb_out_if.source   out_ch,
  plb_cfg_if.sink     cfg_ch
);

  plb_pkg::state_t state_r, state_nxt;

  logic                       op_r;
  logic [plb_pkg::CHAR_W-1:0] char_r;
  logic [plb_pkg::TICK_W-1:0] tick_r;

  logic                        off_r;
  logic [plb_pkg::BUSY_W-1:0]  busy_ticks_r;

  logic [LVL_W-1:0]            fill_r, fill_nxt;
  logic [LVL_W-1:0]            n_r, n_nxt;
  logic [LVL_W-1:0]            idx_r, idx_nxt;
  logic [plb_pkg::BUSY_W-1:0]  busy_r, busy_nxt;
  logic [plb_pkg::CNT_W-1:0]   acc_r, acc_nxt;
  logic [plb_pkg::CNT_W-1:0]   prn_r, prn_nxt;
  logic                        empty_r, empty_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        o_line_r, o_line_nxt;
  logic [plb_pkg::CHAR_W-1:0]  o_char_r, o_char_nxt;
  logic                        o_empty_r, o_empty_nxt;
  logic                        o_last_r, o_last_nxt;
  logic                        o_busy_r, o_busy_nxt;
  logic [LVL_W-1:0]            o_level_r, o_level_nxt;
  logic [plb_pkg::CNT_W-1:0]   o_acc_r, o_acc_nxt;
  logic [plb_pkg::CNT_W-1:0]   o_prn_r, o_prn_nxt;

  logic                        wr_en;
  logic [plb_pkg::CHAR_W-1:0]  wr_data;
  logic [plb_pkg::CHAR_W-1:0]  rd_data;
  logic                        slot_free;
  logic                        is_print, is_lower, keep, do_print;
  logic [plb_pkg::BUSY_W-1:0]  tick_ext;
  logic [LVL_W-1:0]            print_n;

  plb_line_store #(
    .DEPTH  (LINE_CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign in_ch.ready  = (state_r == plb_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign slot_free    = !out_valid_r || out_ch.ready;

  assign is_print = (char_r >= plb_pkg::PRINT_LO) && (char_r <= plb_pkg::PRINT_HI);
  assign is_lower = (char_r >= plb_pkg::LOWER_A) && (char_r <= plb_pkg::LOWER_Z);
  assign keep     = is_print || is_lower;
  assign wr_data  = is_lower ? (char_r - plb_pkg::CASE_OFFSET) : char_r;
  assign tick_ext = {{(plb_pkg::BUSY_W - plb_pkg::TICK_W){1'b0}}, tick_r};

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    acc_nxt       = acc_r;
    prn_nxt       = prn_r;
    empty_nxt     = empty_r;
    wr_en         = 1'b0;
    do_print      = 1'b0;
    print_n       = fill_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_line_nxt    = o_line_r;
    o_char_nxt    = o_char_r;
    o_empty_nxt   = o_empty_r;
    o_last_nxt    = o_last_r;
    o_busy_nxt    = o_busy_r;
    o_level_nxt   = o_level_r;
    o_acc_nxt     = o_acc_r;
    o_prn_nxt     = o_prn_r;

    case (state_r)
      plb_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = plb_pkg::ST_EXEC;
        end
      end
      plb_pkg::ST_EXEC: begin
        empty_nxt = 1'b0;
        state_nxt = plb_pkg::ST_STATUS;
        if (op_r == plb_pkg::OP_TICK) begin
          busy_nxt = (busy_r > tick_ext) ? (busy_r - tick_ext) : '0;
        end else if (off_r) begin
          state_nxt = plb_pkg::ST_STATUS;
        end else if (char_r == plb_pkg::CHAR_CR) begin
          do_print = 1'b1;
        end else if (keep) begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + 1'b1;
          acc_nxt  = acc_r + 1'b1;
          if (fill_r == LVL_W'(LINE_CAPACITY - 1)) begin
            do_print = 1'b1;
            print_n  = LVL_W'(LINE_CAPACITY);
          end
        end
        if (do_print) begin
          fill_nxt = '0;
          prn_nxt  = prn_r + 1'b1;
          busy_nxt = busy_ticks_r;
          n_nxt    = print_n;
          idx_nxt  = '0;
          if (print_n == '0) begin
            empty_nxt = 1'b1;
          end else begin
            state_nxt = plb_pkg::ST_READ;
          end
        end
      end
      plb_pkg::ST_STATUS: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_line_nxt    = empty_r;
          o_char_nxt    = '0;
          o_empty_nxt   = empty_r;
          o_last_nxt    = 1'b1;
          o_busy_nxt    = (busy_r != '0);
          o_level_nxt   = fill_r;
          o_acc_nxt     = acc_r;
          o_prn_nxt     = prn_r;
          state_nxt     = plb_pkg::ST_IDLE;
        end
      end
      plb_pkg::ST_READ: begin
        state_nxt = plb_pkg::ST_EMIT;
      end
      plb_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_line_nxt    = 1'b1;
          o_char_nxt    = rd_data;
          o_empty_nxt   = 1'b0;
          o_last_nxt    = (idx_r + 1'b1 == n_r);
          o_busy_nxt    = (busy_r != '0);
          o_level_nxt   = fill_r;
          o_acc_nxt     = acc_r;
          o_prn_nxt     = prn_r;
          if (idx_r + 1'b1 == n_r) begin
            state_nxt = plb_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = plb_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = plb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= plb_pkg::ST_IDLE;
      fill_r       <= '0;
      busy_r       <= '0;
      acc_r        <= '0;
      prn_r        <= '0;
      out_valid_r  <= 1'b0;
      off_r        <= 1'b0;
      busy_ticks_r <= plb_pkg::BUSY_TICKS_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      busy_r      <= busy_nxt;
      acc_r       <= acc_nxt;
      prn_r       <= prn_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          plb_pkg::CFG_PRINTER_OFF: off_r        <= cfg_ch.data[0];
          plb_pkg::CFG_BUSY_TICKS:  busy_ticks_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r   <= in_ch.operation;
      char_r <= in_ch.char_byte[plb_pkg::CHAR_W-1:0];
      tick_r <= in_ch.tick_count;
    end
    n_r       <= n_nxt;
    idx_r     <= idx_nxt;
    empty_r   <= empty_nxt;
    o_line_r  <= o_line_nxt;
    o_char_r  <= o_char_nxt;
    o_empty_r <= o_empty_nxt;
    o_last_r  <= o_last_nxt;
    o_busy_r  <= o_busy_nxt;
    o_level_r <= o_level_nxt;
    o_acc_r   <= o_acc_nxt;
    o_prn_r   <= o_prn_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.line_valid     = o_line_r;
  assign out_ch.line_char      = o_char_r;
  assign out_ch.empty_line     = o_empty_r;
  assign out_ch.last           = o_last_r;
  assign out_ch.mech_busy      = o_busy_r;
  assign out_ch.buffer_level   = o_level_r;
  assign out_ch.chars_accepted = o_acc_r;
  assign out_ch.lines_printed  = o_prn_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LVL_W'(LINE_CAPACITY))
    else $error("line buffer level beyond capacity");

  a_drain_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plb_pkg::ST_READ || state_r == plb_pkg::ST_EMIT) |-> fill_r == '0)
    else $error("buffer level not cleared while printing");

  a_drain_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plb_pkg::ST_READ || state_r == plb_pkg::ST_EMIT) |-> idx_r < n_r)
    else $error("print index past line length");

  a_emit_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plb_pkg::ST_EMIT && slot_free) |=> (out_ch.valid && out_ch.line_valid
      && !out_ch.empty_line))
    else $error("printed character not loaded as line result");

endmodule
`default_nettype wire

// ===== hw/rtl/plb_line_store.sv =====
// Line character memory: one write port, one registered read port.
`default_nettype none
module plb_line_store #(
  parameter int DEPTH  = plb_pkg::LINE_CAPACITY_DEF,
  parameter int ADDR_W = 6
) (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire  [ADDR_W-1:0]          wr_addr,
  input  wire  [plb_pkg::CHAR_W-1:0] wr_data,
  input  wire  [ADDR_W-1:0]          rd_addr,
  output logic [plb_pkg::CHAR_W-1:0] rd_data
);

  logic [plb_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
